// File: hdl/hpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared widths, register codes and types for the Householder poll-direction
// generator.
// ----------------------------------------------------------------------------
package hpd_pkg;

   localparam int DIM_DEF       = 4;
   localparam int MAX_SHIFT_DEF = 30;

   localparam int VEC_W   = 16;
   localparam int IDX_W   = 6;
   localparam int SHIFT_W = 5;
   localparam int LIM_W   = 17;
   localparam int DIR_W   = 34;
   localparam int POS_W   = 3;
   localparam int PROD_W  = 2 * VEC_W;
   localparam int H_W     = 19;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 80;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_EXP_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LIMIT = 2'd1;

   localparam logic [LIM_W-1:0] CLAMP_RESET = 17'd32768;

   typedef struct packed {
      logic signed [VEC_W-1:0] vi;
      logic signed [VEC_W-1:0] vj;
      logic [SHIFT_W-1:0]      shift;
   } entry_op_type;

   typedef struct packed {
      logic mul_en;
      logic scl_en;
      logic diag;
   } stage_ctl_type;

endpackage

// File: hdl/hpd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_store
// Vector element and row shift memory: one write port, two registered read
// ports (row and column).
// ----------------------------------------------------------------------------
module hpd_store #(
   parameter int DIM = hpd_pkg::DIM_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DIM)-1:0]      wr_addr,
   input  logic signed [hpd_pkg::VEC_W-1:0] wr_vec,
   input  logic [hpd_pkg::SHIFT_W-1:0] wr_shift,
   input  logic [$clog2(DIM)-1:0]      rd_row,
   input  logic [$clog2(DIM)-1:0]      rd_col,
   output hpd_pkg::entry_op_type       rd_op
);
   import hpd_pkg::*;

   logic signed [VEC_W-1:0] vec_mem [DIM];
   logic [SHIFT_W-1:0]      sh_mem  [DIM];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_mem[wr_addr] <= wr_vec;
         sh_mem[wr_addr]  <= wr_shift;
      end
   end

   always_ff @(posedge clock) begin
      rd_op.vi    <= vec_mem[rd_row];
      rd_op.vj    <= vec_mem[rd_col];
      rd_op.shift <= sh_mem[rd_row];
   end

endmodule

// File: hdl/hpd_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_entry
// Shared entry unit: multiply stage, then clamp, scale and round stage.
// ----------------------------------------------------------------------------
module hpd_entry (
   input  logic                              clock,
   input  hpd_pkg::stage_ctl_type            ctl,
   input  hpd_pkg::entry_op_type             op,
   input  logic [hpd_pkg::LIM_W-1:0]         clamp_limit,
   output logic signed [hpd_pkg::DIR_W-1:0]  pos_dir,
   output logic signed [hpd_pkg::DIR_W-1:0]  neg_dir
);
   import hpd_pkg::*;

   localparam int SCALED_W = LIM_W + (1 << SHIFT_W);
   localparam int FRAC     = 15;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     diag_ff;
   logic [SHIFT_W-1:0]       shift_ff;

   logic signed [H_W-1:0]    fl;
   logic signed [H_W-1:0]    h_raw;
   logic signed [H_W-1:0]    lim;
   logic signed [H_W-1:0]    h_clamp;
   logic signed [H_W-1:0]    h_abs;
   logic                     neg;
   logic [SCALED_W-1:0]      scaled;
   logic [DIR_W-1:0]         rnd;
   logic signed [DIR_W-1:0]  pos_in;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff  <= op.vi * op.vj;
         diag_ff  <= ctl.diag;
         shift_ff <= op.shift;
      end
   end

   always_comb begin
      fl      = H_W'(prod_ff >>> 14);
      h_raw   = (diag_ff ? H_W'(32768) : H_W'(0)) - fl;
      lim     = $signed({{(H_W-LIM_W){1'b0}}, clamp_limit});
      if (h_raw > lim) begin
         h_clamp = lim;
      end else if (h_raw < -lim) begin
         h_clamp = -lim;
      end else begin
         h_clamp = h_raw;
      end
      neg     = h_clamp[H_W-1];
      h_abs   = neg ? -h_clamp : h_clamp;
      scaled  = ({{(SCALED_W-LIM_W){1'b0}}, h_abs[LIM_W-1:0]} << shift_ff)
                + SCALED_W'(1 << (FRAC - 1));
      rnd     = scaled[FRAC +: DIR_W];
      pos_in  = neg ? -$signed(rnd) : $signed(rnd);
   end

   always_ff @(posedge clock) begin
      if (ctl.scl_en) begin
         pos_dir <= pos_in;
         neg_dir <= -pos_in;
      end
   end

endmodule

// File: hdl/householder_poll_direction_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// householder_poll_direction_gen
// Loads DIM vector elements with row shifts, then emits the DIM x DIM scaled
// Householder matrix entries in row-major order through one shared entry unit.
// After the last load beat each entry goes in turn through the memory read,
// multiply, scale and output beat states, one entry at a time, and the output
// beat can stall; one load beat per cycle while in the load state.
// Reset: synchronous, clears load count, sequencer and registers to defaults.
// ----------------------------------------------------------------------------
module householder_poll_direction_gen #(
   parameter int DIM       = hpd_pkg::DIM_DEF,
   parameter int MAX_SHIFT = hpd_pkg::MAX_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // rand_elem[15:0], frame_index[21:16], mesh_index[27:22], zero pad
   input  logic [hpd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row[2:0], col[5:3], pos_dir[39:6], neg_dir[73:40], zero pad
   output logic [hpd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hpd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hpd_pkg::*;

   localparam int CNT_W = $clog2(DIM);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(DIM - 1);
   localparam logic signed [7:0] MAX_S   = 8'(MAX_SHIFT);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   exp_offset_ff;
   logic [LIM_W-1:0]   clamp_ff;

   logic                    load_beat;
   logic                    out_beat;
   logic signed [VEC_W-1:0] rand_elem;
   logic [IDX_W-1:0]        frame_index;
   logic [IDX_W-1:0]        mesh_index;
   logic signed [7:0]       sdiff;
   logic [SHIFT_W-1:0]      row_shift;
   entry_op_type            op;
   stage_ctl_type           ctl;
   logic signed [DIR_W-1:0] pos_dir;
   logic signed [DIR_W-1:0] neg_dir;

   assign rand_elem   = req_tdata[15:0];
   assign frame_index = req_tdata[21:16];
   assign mesh_index  = req_tdata[27:22];

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign csr_ready  = 1'b1;
   assign load_beat  = req_tvalid && req_tready;
   assign out_beat   = rsp_tvalid && rsp_tready;

   always_comb begin
      sdiff = $signed({2'b00, frame_index}) - $signed({2'b00, mesh_index})
              + $signed({2'b00, exp_offset_ff});
      if (sdiff < 8'sd0) begin
         row_shift = '0;
      end else if (sdiff > MAX_S) begin
         row_shift = SHIFT_W'(MAX_SHIFT);
      end else begin
         row_shift = sdiff[SHIFT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_beat) begin
               if (slot_ff == LAST_IDX) begin
                  slot_in  = '0;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_READ;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_beat) begin
               state_in = ST_READ;
               if (col_ff == LAST_IDX) begin
                  col_in = '0;
                  if (row_ff == LAST_IDX) begin
                     state_in = ST_LOAD;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         slot_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_offset_ff <= '0;
         clamp_ff      <= CLAMP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXP_OFFSET:  exp_offset_ff <= csr_data[IDX_W-1:0];
            CSR_CLAMP_LIMIT: clamp_ff      <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign ctl.mul_en = (state_ff == ST_MUL);
   assign ctl.scl_en = (state_ff == ST_SCALE);
   assign ctl.diag   = (row_ff == col_ff);

   hpd_store #(
      .DIM (DIM)
   ) u_store (
      .clock    (clock),
      .wr_en    (load_beat),
      .wr_addr  (slot_ff),
      .wr_vec   (rand_elem),
      .wr_shift (row_shift),
      .rd_row   (row_ff),
      .rd_col   (col_ff),
      .rd_op    (op)
   );

   hpd_entry u_entry (
      .clock       (clock),
      .ctl         (ctl),
      .op          (op),
      .clamp_limit (clamp_ff),
      .pos_dir     (pos_dir),
      .neg_dir     (neg_dir)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - 2*POS_W - 2*DIR_W){1'b0}},
                       neg_dir, pos_dir, POS_W'(col_ff), POS_W'(row_ff)};
   assign rsp_tlast = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("load and emit overlap");

   a_negation: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DIR_W'(pos_dir + neg_dir) == '0))
      else $error("neg_dir is not the negation of pos_dir");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to loading after last entry");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      (load_beat && slot_ff == LAST_IDX) |=> (state_ff == ST_READ && row_ff == '0
                                              && col_ff == '0))
      else $error("emission did not start at entry zero");

endmodule
